// ===== hw/rtl/lcab_pkg.sv =====
package lcab_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LOG_LEVELS = 10;
	localparam int NODE_W     = 11;
	localparam int IDX_W      = $clog2(MAX_NODES);
	localparam int LVL_W      = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
	localparam int DEPTH_W    = LOG_LEVELS;
	localparam int EDGE_MAX   = MAX_NODES - 1;
	localparam int ECNT_W     = $clog2(MAX_NODES);
	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic              is_query;
		logic              ok;        // both ends in range
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
	} lcab_item_t;

	function automatic logic in_range(input logic [NODE_W-1:0] n);
		return (n != '0) && (32'(n) <= MAX_NODES);
	endfunction

	function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] n);
		logic [NODE_W:0] t;
		t = {1'b0, n} - (NODE_W+1)'(1);
		return IDX_W'(t);
	endfunction

endpackage

// ===== hw/rtl/lcab_front.sv =====
module lcab_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic [lcab_pkg::NODE_W-1:0] node_a,
	input  logic [lcab_pkg::NODE_W-1:0] node_b,
	output logic                       item_valid,
	output lcab_pkg::lcab_item_t        item,
	input  logic                       item_take
);
	import lcab_pkg::*;

	lcab_item_t        fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wp_q, rp_q;
	logic [FPTR_W:0]   cnt_q;
	logic              push;
	lcab_item_t        new_item;

	assign in_stall   = (cnt_q == (FPTR_W+1)'(FIFO_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = fifo_q[rp_q];
	assign push       = in_valid && !in_stall;

	always_comb begin
		new_item.is_query = cmd;
		new_item.ok       = in_range(node_a) && in_range(node_b);
		new_item.a        = node_a;
		new_item.b        = node_b;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FPTR_W'(1);
			end
			if (item_take) begin
				rp_q <= rp_q + FPTR_W'(1);
			end
			case ({push, item_take})
				2'b10:   cnt_q <= cnt_q + (FPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (FPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lcab_back.sv =====
module lcab_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	input  lcab_pkg::lcab_item_t         item,
	output logic                        item_take,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lcab_pkg::NODE_W-1:0] ancestor,
	output logic                        error
);
	import lcab_pkg::*;

	localparam int AADDR_W = IDX_W + LVL_W;

	typedef enum logic [4:0] {
		S_IDLE, B_CLR, B_ROOT, B_POP, B_SRD, B_SDEP, B_ERD, B_ECHK, B_VSEEN,
		B_LRD, B_LWR, B_ENQ, Q_DA, Q_DB, Q_CHK, Q_UP, Q_UPW, Q_EQ, Q_LS, Q_LT,
		Q_LC, Q_FIN, Q_RES
	} state_t;

	state_t state_q;

	// memories
	logic [NODE_W-1:0]  ea_mem [EDGE_MAX];
	logic [NODE_W-1:0]  eb_mem [EDGE_MAX];
	logic [DEPTH_W:0]   dep_mem [MAX_NODES];   // {seen, depth}
	logic [NODE_W-1:0]  anc_mem [2**AADDR_W];
	logic [NODE_W-1:0]  wq_mem [MAX_NODES];

	logic [NODE_W-1:0]  ea_rd_q, eb_rd_q, anc_rd_q, wq_rd_q;
	logic [DEPTH_W:0]   dep_rd_q;

	logic               edge_we;
	logic               dep_we;
	logic [IDX_W-1:0]   dep_waddr, dep_raddr;
	logic [DEPTH_W:0]   dep_wdata;
	logic               anc_we;
	logic [AADDR_W-1:0] anc_waddr, anc_raddr;
	logic [NODE_W-1:0]  anc_wdata;
	logic               wq_we;
	logic [IDX_W-1:0]   wq_waddr;
	logic [NODE_W-1:0]  wq_wdata;

	// control and working registers
	logic               built_q;
	logic [ECNT_W-1:0]  ecnt_q, e_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W:0]     head_q, tail_q;
	logic [NODE_W-1:0]  s_q, t_q, v_q, mid_q;
	logic [DEPTH_W-1:0] ds_q, diff_q;
	logic               sa_q;
	logic [LVL_W-1:0]   k_q;
	logic               out_valid_q, error_q;
	logic [NODE_W-1:0]  ancestor_q;

	assign out_valid = out_valid_q;
	assign ancestor  = ancestor_q;
	assign error     = error_q;

	always_comb begin
		item_take = 1'b0;
		edge_we   = 1'b0;
		if (state_q == S_IDLE && item_valid) begin
			if (!item.is_query) begin
				item_take = 1'b1;
				edge_we   = !built_q && item.ok && (ecnt_q != ECNT_W'(EDGE_MAX));
			end else if (built_q && !out_valid_q) begin
				item_take = 1'b1;
			end
		end
	end

	always_comb begin
		dep_we    = 1'b0;
		dep_waddr = node_idx(v_q);
		dep_wdata = {1'b1, ds_q + DEPTH_W'(1)};
		dep_raddr = node_idx(s_q);
		anc_we    = 1'b0;
		anc_waddr = {node_idx(v_q), k_q};
		anc_wdata = anc_rd_q;
		anc_raddr = {node_idx(s_q), k_q};
		wq_we     = 1'b0;
		wq_waddr  = tail_q[IDX_W-1:0];
		wq_wdata  = v_q;
		unique case (state_q)
			B_CLR: begin
				dep_we    = 1'b1;
				dep_waddr = cnt_q;
				dep_wdata = '0;
			end
			B_ROOT: begin
				dep_we    = 1'b1;
				dep_waddr = '0;
				dep_wdata = {1'b1, {DEPTH_W{1'b0}}};
				anc_we    = 1'b1;
				anc_waddr = {{IDX_W{1'b0}}, k_q};
				anc_wdata = NODE_W'(1);
				wq_we     = 1'b1;
				wq_waddr  = '0;
				wq_wdata  = NODE_W'(1);
			end
			B_SRD:   dep_raddr = node_idx(wq_rd_q);
			B_ECHK: begin
				dep_raddr = (ea_rd_q == s_q) ? node_idx(eb_rd_q) : node_idx(ea_rd_q);
			end
			B_VSEEN: begin
				if (!dep_rd_q[DEPTH_W]) begin
					dep_we    = 1'b1;
					anc_we    = 1'b1;
					anc_waddr = {node_idx(v_q), {LVL_W{1'b0}}};
					anc_wdata = s_q;
				end
			end
			B_LRD:   anc_raddr = {node_idx(mid_q), k_q - LVL_W'(1)};
			B_LWR:   anc_we = 1'b1;
			B_ENQ:   wq_we = (tail_q != (IDX_W+1)'(MAX_NODES));
			Q_DB:    dep_raddr = node_idx(t_q);
			Q_LT:    anc_raddr = {node_idx(t_q), k_q};
			Q_FIN:   anc_raddr = {node_idx(s_q), {LVL_W{1'b0}}};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			ea_mem[ecnt_q] <= item.a;
			eb_mem[ecnt_q] <= item.b;
		end
		ea_rd_q <= ea_mem[e_q];
		eb_rd_q <= eb_mem[e_q];
	end

	always_ff @(posedge clk) begin
		if (dep_we) begin
			dep_mem[dep_waddr] <= dep_wdata;
		end
		dep_rd_q <= dep_mem[dep_raddr];
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_waddr] <= anc_wdata;
		end
		anc_rd_q <= anc_mem[anc_raddr];
	end

	always_ff @(posedge clk) begin
		if (wq_we) begin
			wq_mem[wq_waddr] <= wq_wdata;
		end
		wq_rd_q <= wq_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			built_q     <= 1'b0;
			ecnt_q      <= '0;
			e_q         <= '0;
			cnt_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			error_q     <= 1'b0;
			ancestor_q  <= '0;
			s_q         <= '0;
			t_q         <= '0;
			v_q         <= '0;
			mid_q       <= '0;
			ds_q        <= '0;
			diff_q      <= '0;
			sa_q        <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (edge_we) begin
				ecnt_q <= ecnt_q + ECNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && item.is_query) begin
						if (!built_q) begin
							cnt_q   <= '0;
							state_q <= B_CLR;
						end else if (!out_valid_q) begin
							s_q <= item.a;
							t_q <= item.b;
							if (!item.ok) begin
								out_valid_q <= 1'b1;
								error_q     <= 1'b1;
								ancestor_q  <= '0;
							end else begin
								state_q <= Q_DA;
							end
						end
					end
				end
				// build: clear visit marks, seed the root, then walk
				B_CLR: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == IDX_W'(MAX_NODES - 1)) begin
						k_q     <= '0;
						state_q <= B_ROOT;
					end
				end
				B_ROOT: begin
					k_q <= k_q + LVL_W'(1);
					if (k_q == LVL_W'(LOG_LEVELS - 1)) begin
						head_q  <= '0;
						tail_q  <= (IDX_W+1)'(1);
						state_q <= B_POP;
					end
				end
				B_POP: begin
					if (head_q == tail_q) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= B_SRD;
					end
				end
				B_SRD: begin
					s_q     <= wq_rd_q;
					head_q  <= head_q + (IDX_W+1)'(1);
					state_q <= B_SDEP;
				end
				B_SDEP: begin
					ds_q <= dep_rd_q[DEPTH_W-1:0];
					e_q  <= '0;
					// depth cap reached: no children
					state_q <= (&dep_rd_q[DEPTH_W-1:0]) ? B_POP : B_ERD;
				end
				B_ERD: begin
					state_q <= (e_q == ecnt_q) ? B_POP : B_ECHK;
				end
				B_ECHK: begin
					if (ea_rd_q == s_q) begin
						v_q     <= eb_rd_q;
						state_q <= B_VSEEN;
					end else if (eb_rd_q == s_q) begin
						v_q     <= ea_rd_q;
						state_q <= B_VSEEN;
					end else begin
						e_q     <= e_q + ECNT_W'(1);
						state_q <= B_ERD;
					end
				end
				B_VSEEN: begin
					if (dep_rd_q[DEPTH_W]) begin
						e_q     <= e_q + ECNT_W'(1);
						state_q <= B_ERD;
					end else begin
						mid_q   <= s_q;
						k_q     <= LVL_W'(1);
						state_q <= (LOG_LEVELS == 1) ? B_ENQ : B_LRD;
					end
				end
				B_LRD:   state_q <= B_LWR;
				B_LWR: begin
					mid_q <= anc_rd_q;
					if (k_q == LVL_W'(LOG_LEVELS - 1)) begin
						state_q <= B_ENQ;
					end else begin
						k_q     <= k_q + LVL_W'(1);
						state_q <= B_LRD;
					end
				end
				B_ENQ: begin
					if (tail_q != (IDX_W+1)'(MAX_NODES)) begin
						tail_q <= tail_q + (IDX_W+1)'(1);
					end
					e_q     <= e_q + ECNT_W'(1);
					state_q <= B_ERD;
				end
				// query
				Q_DA:    state_q <= Q_DB;
				Q_DB: begin
					sa_q    <= dep_rd_q[DEPTH_W];
					ds_q    <= dep_rd_q[DEPTH_W-1:0];
					state_q <= Q_CHK;
				end
				Q_CHK: begin
					k_q <= '0;
					if (!sa_q || !dep_rd_q[DEPTH_W]) begin
						out_valid_q <= 1'b1;
						error_q     <= 1'b1;
						ancestor_q  <= '0;
						state_q     <= S_IDLE;
					end else begin
						if (ds_q < dep_rd_q[DEPTH_W-1:0]) begin
							s_q    <= t_q;
							t_q    <= s_q;
							diff_q <= dep_rd_q[DEPTH_W-1:0] - ds_q;
						end else begin
							diff_q <= ds_q - dep_rd_q[DEPTH_W-1:0];
						end
						state_q <= Q_UP;
					end
				end
				Q_UP: begin
					if (diff_q == '0) begin
						state_q <= Q_EQ;
					end else if (diff_q[0]) begin
						state_q <= Q_UPW;
					end else begin
						diff_q <= diff_q >> 1;
						k_q    <= k_q + LVL_W'(1);
					end
				end
				Q_UPW: begin
					s_q     <= anc_rd_q;
					diff_q  <= diff_q >> 1;
					k_q     <= k_q + LVL_W'(1);
					state_q <= Q_UP;
				end
				Q_EQ: begin
					if (s_q == t_q) begin
						out_valid_q <= 1'b1;
						error_q     <= 1'b0;
						ancestor_q  <= s_q;
						state_q     <= S_IDLE;
					end else begin
						k_q     <= LVL_W'(LOG_LEVELS - 1);
						state_q <= Q_LS;
					end
				end
				Q_LS:    state_q <= Q_LT;
				Q_LT: begin
					mid_q   <= anc_rd_q;
					state_q <= Q_LC;
				end
				Q_LC: begin
					if (mid_q != anc_rd_q) begin
						s_q <= mid_q;
						t_q <= anc_rd_q;
					end
					if (k_q == '0) begin
						state_q <= Q_FIN;
					end else begin
						k_q     <= k_q - LVL_W'(1);
						state_q <= Q_LS;
					end
				end
				Q_FIN:   state_q <= Q_RES;
				Q_RES: begin
					out_valid_q <= 1'b1;
					error_q     <= 1'b0;
					ancestor_q  <= anc_rd_q;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/tree_lca_binary_lifting.sv =====
// Lowest common ancestor engine over a stored tree.
// Input channel (in_valid / in_stall): cmd 0 transfers an edge node_a-node_b,
// cmd 1 transfers a query for the pair. Edges give no result; each query
// gives one result on the output channel (out_valid / out_stall): ancestor
// and error (error set, ancestor 0, for a node out of range or unreached).
// A four-entry queue sits behind the input, so items are taken while the
// engine is busy; in_stall rises only when that queue is full.
// The first query builds the tree: a sweep clears the visit marks, then a
// breadth-first walk scans the edge list once per reached node. Edges that
// arrive after that are dropped.
// A query for a node out of range gets its error result straight from the
// idle state. Other queries lift the deeper node to the depth of the other
// through the single read port of the ancestor memory, and finish there when
// one node is an ancestor of the other. Edges are taken from the queue
// whenever the engine is idle. The result waits in an output register while
// out_stall is high and the next query starts only once it has left.
// Reset clears all control state and forgets the stored edges and tree.
module tree_lca_binary_lifting (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [lcab_pkg::NODE_W-1:0] node_a,
	input  logic [lcab_pkg::NODE_W-1:0] node_b,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lcab_pkg::NODE_W-1:0] ancestor,
	output logic                        error
);
	import lcab_pkg::*;

	lcab_item_t item;
	logic       item_valid, item_take;

	lcab_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .node_a(node_a), .node_b(node_b),
		.item_valid(item_valid), .item(item), .item_take(item_take)
	);

	lcab_back u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item(item),
		.item_take(item_take), .out_valid(out_valid), .out_stall(out_stall),
		.ancestor(ancestor), .error(error)
	);

endmodule

// ===== hw/rtl/lcab_checker.sv =====
module lcab_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lcab_pkg::NODE_W-1:0] ancestor,
	input logic                        error
);
	import lcab_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ancestor) && $stable(error))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> ancestor == '0)
		else $error("error result with nonzero ancestor");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> ancestor != '0)
		else $error("good result with ancestor 0");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> 32'(ancestor) <= MAX_NODES)
		else $error("ancestor out of range");

endmodule

bind tree_lca_binary_lifting lcab_checker u_lcab_checker (.*);

// ===== test/tree_lca_binary_lifting_test.sv =====
`timescale 1ns / 1ps

module tree_lca_binary_lifting_test;
	import lcab_pkg::*;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam int TREE_NODES = 200;
	localparam int CHAIN_END  = 100;
	localparam int JUNK_LO    = 900;
	localparam int IDLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic              cmd;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		bit                fixed;
		logic [NODE_W-1:0] anc;
		logic              err;
	} lca_item_t;

	typedef struct {
		logic [NODE_W-1:0] anc;
		logic              err;
	} lca_result_t;

	logic clk, arst_n;
	logic in_valid, in_stall, cmd;
	logic [NODE_W-1:0] node_a, node_b;
	logic out_valid, out_stall;
	logic [NODE_W-1:0] ancestor;
	logic error;

	tree_lca_binary_lifting dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.ancestor(ancestor), .error(error)
	);

	lca_item_t   stim[$];
	lca_result_t pending[$];
	int          failures = 0;
	int          sent = 0;
	bit          hold_req = 0;
	int          hold_at;

	// predictor state
	logic [NODE_W-1:0] store_a[0:EDGE_MAX-1];
	logic [NODE_W-1:0] store_b[0:EDGE_MAX-1];
	int                store_cnt = 0;
	int                depth_of[1:MAX_NODES];
	bit                reached[1:MAX_NODES];
	logic [NODE_W-1:0] lift[1:MAX_NODES][0:LOG_LEVELS-1];
	int                walk[$];
	bit                built = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic bit node_ok(logic [NODE_W-1:0] n);
		return n >= 1 && n <= MAX_NODES;
	endfunction

	function automatic void grow_tree();
		int s, v, cap;
		cap = (1 << LOG_LEVELS) - 1;
		for (int n = 1; n <= MAX_NODES; n++) reached[n] = 0;
		reached[1] = 1;
		depth_of[1] = 0;
		for (int k = 0; k < LOG_LEVELS; k++) lift[1][k] = 1;
		walk = {1};
		while (walk.size() > 0) begin
			s = walk.pop_front();
			if (depth_of[s] >= cap) continue;
			for (int e = 0; e < store_cnt; e++) begin
				if (store_a[e] == s) v = store_b[e];
				else if (store_b[e] == s) v = store_a[e];
				else continue;
				if (reached[v]) continue;
				reached[v] = 1;
				depth_of[v] = depth_of[s] + 1;
				lift[v][0] = s;
				for (int k = 1; k < LOG_LEVELS; k++) lift[v][k] = lift[lift[v][k-1]][k-1];
				walk.insert(walk.size(), v);
			end
		end
		built = 1;
	endfunction

	function automatic logic [NODE_W-1:0] common_root(int s, int t);
		int tmp, diff, as_, at_;
		if (depth_of[s] < depth_of[t]) begin
			tmp = s; s = t; t = tmp;
		end
		diff = depth_of[s] - depth_of[t];
		for (int k = 0; k < LOG_LEVELS; k++)
			if ((diff >> k) & 1) s = lift[s][k];
		if (s == t) return s;
		for (int k = LOG_LEVELS - 1; k >= 0; k--) begin
			as_ = lift[s][k];
			at_ = lift[t][k];
			if (as_ != at_) begin
				s = as_; t = at_;
			end
		end
		return lift[s][0];
	endfunction

	// returns 1 when the item gives a result
	function automatic bit predict_lca(lca_item_t it, output lca_result_t r);
		if (it.cmd == CMD_EDGE) begin
			if (!built && node_ok(it.a) && node_ok(it.b) && store_cnt < EDGE_MAX) begin
				store_a[store_cnt] = it.a;
				store_b[store_cnt] = it.b;
				store_cnt++;
			end
			return 0;
		end
		if (!built) grow_tree();
		if (!node_ok(it.a) || !node_ok(it.b) || !reached[it.a] || !reached[it.b]) begin
			r.anc = '0;
			r.err = 1;
		end else begin
			r.anc = common_root(it.a, it.b);
			r.err = 0;
		end
		return 1;
	endfunction

	function automatic lca_item_t mk(logic c, int a, int b, bit f = 0, int anc = 0,
			bit err = 0);
		lca_item_t it;
		it.cmd = c; it.a = a; it.b = b; it.fixed = f; it.anc = anc; it.err = err;
		return it;
	endfunction

	function automatic int bad_node();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_NODES + 1, 2047);
	endfunction

	function automatic void add_edge(int a, int b);
		if ($urandom_range(0, 1)) stim.insert(stim.size(), mk(CMD_EDGE, a, b));
		else stim.insert(stim.size(), mk(CMD_EDGE, b, a));
	endfunction

	task automatic build_stim();
		lca_item_t table_rows[$];
		int stored, q, a, b;
		// tree: a long chain, then random branches; extra repeated and cycle edges mixed in
		stored = 0;
		for (int i = 2; i <= TREE_NODES; i++) begin
			if (i <= CHAIN_END) add_edge(i - 1, i);
			else add_edge($urandom_range(1, i - 1), i);
			stored++;
			if ($urandom_range(0, 4) == 0) begin
				add_edge($urandom_range(1, i), $urandom_range(1, i));
				stored++;
			end
			if ($urandom_range(0, 9) == 0)
				stim.insert(stim.size(),
					mk(CMD_EDGE, bad_node(), $urandom_range(0, 2047)));
		end
		// disconnected part fills the edge list
		while (stored < EDGE_MAX) begin
			add_edge($urandom_range(JUNK_LO, MAX_NODES), $urandom_range(JUNK_LO, MAX_NODES));
			stored++;
			if ($urandom_range(0, 49) == 0)
				stim.insert(stim.size(),
					mk(CMD_EDGE, $urandom_range(1, 2047), bad_node()));
		end
		table_rows = {
			mk(CMD_EDGE, 1, 1000),          // list full: dropped
			mk(CMD_EDGE, 0, 0),
			mk(CMD_EDGE, 2047, 2047),
			mk(CMD_QUERY, 1, 1, 1, 1, 0),
			mk(CMD_QUERY, 2, 1, 1, 1, 0),
			mk(CMD_QUERY, 1, 2, 1, 1, 0),
			mk(CMD_QUERY, 0, 1, 1, 0, 1),
			mk(CMD_QUERY, 1, 0, 1, 0, 1),
			mk(CMD_QUERY, 1025, 1, 1, 0, 1),
			mk(CMD_QUERY, 2047, 2047, 1, 0, 1),
			mk(CMD_QUERY, 1024, 1024, 1, 0, 1),
			mk(CMD_QUERY, 1000, 1, 1, 0, 1),
			mk(CMD_EDGE, 1, 3),             // after build: dropped
			mk(CMD_QUERY, 1, 3, 1, 1, 0),
			mk(CMD_QUERY, 100, 100),
			mk(CMD_QUERY, 100, 2),
			mk(CMD_QUERY, 99, 100),
			mk(CMD_QUERY, 100, 200),
			mk(CMD_QUERY, 200, 150),
			mk(CMD_QUERY, 50, 199),
			mk(CMD_QUERY, 3, 100)
		};
		foreach (table_rows[i]) stim.insert(stim.size(), table_rows[i]);
		hold_at = stim.size() + 600;
		for (int i = 0; i < 750; i++) begin
			q = $urandom_range(0, 19);
			if (q == 0) begin
				stim.insert(stim.size(),
					mk(CMD_EDGE, $urandom_range(0, 2047), $urandom_range(0, 2047)));
			end else begin
				a = $urandom_range(1, TREE_NODES);
				b = (q < 6) ? $urandom_range(CHAIN_END - 20, TREE_NODES)
					: $urandom_range(1, TREE_NODES);
				if (q == 18) a = $urandom_range(0, 2047);
				if (q == 19)
					b = ($urandom_range(0, 1)) ? bad_node()
						: $urandom_range(JUNK_LO, MAX_NODES);
				stim.insert(stim.size(), mk(CMD_QUERY, a, b));
			end
		end
	endtask

	initial begin
		in_valid <= 0; cmd <= CMD_EDGE; node_a <= '0; node_b <= '0;
		out_stall <= 0;
		arst_n = 0;
		build_stim();
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	// sender: bursts and gaps
	initial begin
		int pos, burst, gap;
		bit take;
		lca_item_t it;
		pos = 0; burst = 0; gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			take = in_valid && !in_stall;
			if (take) pos++;
			if (in_valid && !take) continue;
			if (pos >= hold_at) hold_req <= 1;
			if (pos < stim.size() && gap == 0) begin
				it = stim[pos];
				in_valid <= 1; cmd <= it.cmd; node_a <= it.a; node_b <= it.b;
				if (burst == 0) burst = $urandom_range(1, 40);
				burst--;
				if (burst == 0) gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				in_valid <= 0;
				if (gap > 0) gap--;
			end
		end
	end

	// receiver stall pattern with one long hold-off
	initial begin
		int mode, span, held;
		bit done_hold;
		mode = 0; span = 0; held = 0; done_hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !done_hold) begin
				out_stall <= 1;
				if (++held >= HOLD_CYCLES) done_hold = 1;
				continue;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(50, 400);
			end
			span--;
			case (mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= (span % 7) < 3;
			endcase
		end
	end

	// input monitor feeds the predictor; sent counts accepted transfers
	always @(posedge clk) begin
		lca_item_t it;
		lca_result_t r;
		if (arst_n && in_valid && !in_stall) begin
			it.cmd = cmd; it.a = node_a; it.b = node_b;
			if (predict_lca(it, r)) begin
				if (stim[sent].fixed) begin
					r.anc = stim[sent].anc;
					r.err = stim[sent].err;
				end
				pending.insert(pending.size(), r);
			end
			sent++;
		end
	end

	// result checker
	always @(posedge clk) begin
		lca_result_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result ancestor=%0d error=%0d", $time, ancestor, error);
				failures++;
			end else begin
				r = pending.pop_front();
				if (ancestor !== r.anc) begin
					$display("%0t: ancestor expected %0d got %0d", $time, r.anc, ancestor);
					failures++;
				end
				if (error !== r.err) begin
					$display("%0t: error expected %0d got %0d", $time, r.err, error);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		wait (stim.size() > 0 && sent >= stim.size());
		while (pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== tree_lca_binary_lifting.f =====
hw/rtl/lcab_pkg.sv
hw/rtl/lcab_front.sv
hw/rtl/lcab_back.sv
hw/rtl/tree_lca_binary_lifting.sv
hw/rtl/lcab_checker.sv
test/tree_lca_binary_lifting_test.sv
